>>> rtl/core/wbpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbpt_pkg
// Types, codes and constants shared by the work/break phase timer core.
// ----------------------------------------------------------------------------
package wbpt_pkg;

   // touch sample width
   localparam int TOUCH_BITS = 12;

   // op codes
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_SNOOZE = 2'd2;
   localparam logic [1:0] OP_END   = 2'd3;

   // phase codes
   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_WORK  = 2'd1;
   localparam logic [1:0] PH_SHORT = 2'd2;
   localparam logic [1:0] PH_LONG  = 2'd3;

   // register indexes
   localparam logic [2:0] CSR_WORK_MIN   = 3'd0;
   localparam logic [2:0] CSR_SHORT_MIN  = 3'd1;
   localparam logic [2:0] CSR_LONG_MIN   = 3'd2;
   localparam logic [2:0] CSR_SNOOZE_MIN = 3'd3;
   localparam logic [2:0] CSR_CYCLES     = 3'd4;
   localparam logic [2:0] CSR_THRESHOLD  = 3'd5;
   localparam logic [2:0] CSR_DEBOUNCE   = 3'd6;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   // register reset values
   localparam logic [7:0]  RST_WORK_MIN   = 8'd25;
   localparam logic [7:0]  RST_SHORT_MIN  = 8'd5;
   localparam logic [7:0]  RST_LONG_MIN   = 8'd15;
   localparam logic [5:0]  RST_SNOOZE_MIN = 6'd5;
   localparam logic [3:0]  RST_CYCLES     = 4'd4;
   localparam logic [TOUCH_BITS-1:0] RST_THRESHOLD = TOUCH_BITS'(100);
   localparam logic [15:0] RST_DEBOUNCE   = 16'd500;

   localparam logic [23:0] MS_PER_MINUTE = 24'd60000;

   // n / 1000 for any 32-bit n: (n * ceil(2^38 / 1000)) >> 38, exact
   localparam logic [28:0] RECIP_1000  = 29'd274877907;
   localparam int          RECIP_SHIFT = 38;
   localparam int          SECONDS_BITS = 23;

   typedef struct packed {
      logic [1:0]            op;
      logic [TOUCH_BITS-1:0] touch_level;
   } req_type;

   typedef struct packed {
      logic [1:0]              phase;
      logic                    awaiting_touch;
      logic [SECONDS_BITS-1:0] remaining_seconds;
      logic [15:0]             completed_work_phases;
      logic [7:0]              snoozes_taken;
      logic                    touch_accepted;
      logic                    phase_changed;
   } rsp_type;

   // minutes to milliseconds, at most 15,300,000
   function automatic logic [31:0] minutes_to_ms(input logic [7:0] minutes);
      logic [23:0] prod;
      prod = {16'd0, minutes} * MS_PER_MINUTE;
      return {8'd0, prod};
   endfunction

endpackage

>>> rtl/core/work_break_phase_timer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// work_break_phase_timer_core
// Work / short break / long break phase timer stepped by millisecond ticks,
// with debounced touch confirmation, snooze and session start/end ops.
// ----------------------------------------------------------------------------
// One item is accepted per clock while the result side keeps up. Each item
// updates the timer state in the cycle it is accepted; its result then moves
// through registered stages: a first stage registers the new state and the
// milliseconds left, a second stage turns the milliseconds into whole seconds
// with a single 32 x 29 reciprocal multiply. A stalled result holds the second
// stage, the first stage still takes one more item, and req_stall rises only
// once both are full. Configuration writes take effect at the next clock edge.
module work_break_phase_timer_core
   import wbpt_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // item input
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   // item result
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   // register writes
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   // configuration registers
   logic [7:0]            work_min_ff, short_min_ff, long_min_ff;
   logic [5:0]            snooze_min_ff;
   logic [3:0]            cycles_ff;
   logic [TOUCH_BITS-1:0] threshold_ff;
   logic [15:0]           debounce_ff;

   // timer state
   logic [1:0]  phase_ff, phase_in;
   logic [31:0] elapsed_ff, elapsed_in;
   logic [31:0] length_ff, length_in;
   logic [15:0] work_count_ff, work_count_in;
   logic [3:0]  to_long_ff, to_long_in;
   logic [7:0]  tally_ff, tally_in;
   logic        waiting_ff, waiting_in;
   logic        was_high_ff, was_high_in;
   logic [15:0] since_touch_ff, since_touch_in;

   // pipeline
   logic        s1_valid_ff, s1_valid_in;
   rsp_type     s1_rsp_ff, s1_rsp_in;
   logic [31:0] s1_left_ms_ff, s1_left_ms_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        req_fire, s2_load;
   logic        accepted, changed, pressed;
   logic [15:0] since_inc;
   logic [3:0]  to_long_inc;
   logic [32:0] snooze_sum;
   logic [60:0] seconds_prod;

   // handshake and stage movement
   assign s2_load     = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = s1_valid_ff && !s2_load;
   assign req_fire    = req_valid && !req_stall;
   assign s1_valid_in = req_fire ? 1'b1 : (s2_load ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s2_load ? s1_valid_ff : rsp_valid_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         work_min_ff   <= RST_WORK_MIN;
         short_min_ff  <= RST_SHORT_MIN;
         long_min_ff   <= RST_LONG_MIN;
         snooze_min_ff <= RST_SNOOZE_MIN;
         cycles_ff     <= RST_CYCLES;
         threshold_ff  <= RST_THRESHOLD;
         debounce_ff   <= RST_DEBOUNCE;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_WORK_MIN:   work_min_ff   <= csr_wdata[7:0];
            CSR_SHORT_MIN:  short_min_ff  <= csr_wdata[7:0];
            CSR_LONG_MIN:   long_min_ff   <= csr_wdata[7:0];
            CSR_SNOOZE_MIN: snooze_min_ff <= csr_wdata[5:0];
            CSR_CYCLES:     cycles_ff     <= csr_wdata[3:0];
            CSR_THRESHOLD:  threshold_ff  <= csr_wdata[TOUCH_BITS-1:0];
            CSR_DEBOUNCE:   debounce_ff   <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // next timer state for the incoming item
   always_comb begin
      phase_in       = phase_ff;
      elapsed_in     = elapsed_ff;
      length_in      = length_ff;
      work_count_in  = work_count_ff;
      to_long_in     = to_long_ff;
      tally_in       = tally_ff;
      waiting_in     = waiting_ff;
      was_high_in    = was_high_ff;
      since_touch_in = since_touch_ff;
      accepted       = 1'b0;
      changed        = 1'b0;
      pressed        = req_data.touch_level > threshold_ff;
      since_inc      = (since_touch_ff != 16'hFFFF) ? since_touch_ff + 16'd1 : since_touch_ff;
      to_long_inc    = to_long_ff + 4'd1;
      snooze_sum     = {1'b0, length_ff} + 33'(minutes_to_ms({2'b00, snooze_min_ff}));

      unique case (req_data.op)
         OP_TICK: begin
            since_touch_in = since_inc;
            if (phase_ff != PH_IDLE) begin
               // debounced rising edge
               if (pressed && !was_high_ff && since_inc > debounce_ff) begin
                  accepted       = 1'b1;
                  since_touch_in = 16'd0;
               end
               was_high_in = pressed;
               if (accepted) begin
                  changed    = 1'b1;
                  elapsed_in = 32'd0;
                  tally_in   = 8'd0;
                  waiting_in = 1'b0;
                  if (phase_ff == PH_WORK) begin
                     work_count_in = work_count_ff + 16'd1;
                     if (to_long_inc >= cycles_ff) begin
                        to_long_in = 4'd0;
                        phase_in   = PH_LONG;
                        length_in  = minutes_to_ms(long_min_ff);
                     end else begin
                        to_long_in = to_long_inc;
                        phase_in   = PH_SHORT;
                        length_in  = minutes_to_ms(short_min_ff);
                     end
                  end else begin
                     phase_in  = PH_WORK;
                     length_in = minutes_to_ms(work_min_ff);
                  end
               end else begin
                  // count time, flag when the phase runs out
                  if (elapsed_ff != 32'hFFFF_FFFF) begin
                     elapsed_in = elapsed_ff + 32'd1;
                  end
                  if (!waiting_ff && elapsed_in >= length_ff) begin
                     waiting_in = 1'b1;
                  end
               end
            end
         end
         OP_START: begin
            phase_in      = PH_WORK;
            length_in     = minutes_to_ms(work_min_ff);
            elapsed_in    = 32'd0;
            work_count_in = 16'd0;
            to_long_in    = 4'd0;
            tally_in      = 8'd0;
            waiting_in    = 1'b0;
            changed       = 1'b1;
         end
         OP_SNOOZE: begin
            if (phase_ff == PH_SHORT || phase_ff == PH_LONG) begin
               length_in = snooze_sum[32] ? 32'hFFFF_FFFF : snooze_sum[31:0];
               if (tally_ff != 8'hFF) begin
                  tally_in = tally_ff + 8'd1;
               end
            end
         end
         OP_END: begin
            changed    = (phase_ff != PH_IDLE);
            phase_in   = PH_IDLE;
            waiting_in = 1'b0;
            elapsed_in = 32'd0;
            length_in  = 32'd0;
         end
         default: ;
      endcase
   end

   // first-stage result: everything but the seconds
   always_comb begin
      s1_rsp_in.phase                 = phase_in;
      s1_rsp_in.awaiting_touch        = waiting_in;
      s1_rsp_in.remaining_seconds     = '0;
      s1_rsp_in.completed_work_phases = work_count_in;
      s1_rsp_in.snoozes_taken         = tally_in;
      s1_rsp_in.touch_accepted        = accepted;
      s1_rsp_in.phase_changed         = changed;
      if (phase_in != PH_IDLE && !waiting_in && length_in > elapsed_in) begin
         s1_left_ms_in = length_in - elapsed_in;
      end else begin
         s1_left_ms_in = 32'd0;
      end
   end

   // timer state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         elapsed_ff     <= 32'd0;
         length_ff      <= 32'd0;
         work_count_ff  <= 16'd0;
         to_long_ff     <= 4'd0;
         tally_ff       <= 8'd0;
         waiting_ff     <= 1'b0;
         was_high_ff    <= 1'b0;
         since_touch_ff <= 16'd0;
      end else if (req_fire) begin
         phase_ff       <= phase_in;
         elapsed_ff     <= elapsed_in;
         length_ff      <= length_in;
         work_count_ff  <= work_count_in;
         to_long_ff     <= to_long_in;
         tally_ff       <= tally_in;
         waiting_ff     <= waiting_in;
         was_high_ff    <= was_high_in;
         since_touch_ff <= since_touch_in;
      end
   end

   // milliseconds to whole seconds
   assign seconds_prod = {29'd0, s1_left_ms_ff} * {32'd0, RECIP_1000};

   // second-stage result with the seconds filled in
   always_comb begin
      rsp_data_in                   = s1_rsp_ff;
      rsp_data_in.remaining_seconds = seconds_prod[RECIP_SHIFT +: SECONDS_BITS];
   end

   // pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_rsp_ff     <= s1_rsp_in;
         s1_left_ms_ff <= s1_left_ms_in;
      end
      if (s2_load && s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   a_wait_not_idle: assert property (@(posedge clock) disable iff (reset)
      waiting_ff |-> phase_ff != PH_IDLE)
      else $error("awaiting flag set while idle");

   a_touch_changes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.touch_accepted |-> rsp_data.phase_changed)
      else $error("accepted touch without phase change");

   a_seconds_only_running: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.remaining_seconds != '0
         |-> !rsp_data.awaiting_touch && rsp_data.phase != PH_IDLE)
      else $error("seconds left while idle or awaiting touch");

   a_accept_clears_debounce: assert property (@(posedge clock) disable iff (reset)
      req_fire && accepted |=> since_touch_ff == 16'd0 && !waiting_ff)
      else $error("touch accepted but debounce count or flag not cleared");

endmodule
